FILE: rtl/cltd_pkg.sv
package cltd_pkg;

    localparam int unsigned NUM_CPUS_DEF = 8;
    localparam int unsigned PCT_STEPS    = 100;

    localparam logic [10:0] DELAY_HEAVY    = 11'd500;
    localparam logic [10:0] DELAY_MODERATE = 11'd750;
    localparam logic [10:0] DELAY_LIGHT    = 11'd2000;

    localparam logic [6:0] MED_HEAVY_PCT   = 7'd65;
    localparam logic [6:0] PRIME_HEAVY_PCT = 7'd75;
    localparam logic [6:0] MED_ACTIVE_PCT  = 7'd30;
    localparam logic [6:0] LITTLE_MOD_PCT  = 7'd30;
    localparam logic [6:0] PRIME_MOD_PCT   = 7'd35;

    localparam logic [2:0] CNT_MAX = 3'd7;

    localparam logic [2:0] REG_LITTLE_LAST = 3'd0;
    localparam logic [2:0] REG_MEDIUM_LAST = 3'd1;
    localparam logic [2:0] REG_HEAVY_UP    = 3'd2;
    localparam logic [2:0] REG_DOWN        = 3'd3;
    localparam logic [2:0] REG_HEAVY_PCT   = 3'd4;
    localparam logic [2:0] REG_MOD_PCT     = 3'd5;

    localparam logic [1:0] TIER_LIGHT    = 2'd0;
    localparam logic [1:0] TIER_MODERATE = 2'd1;
    localparam logic [1:0] TIER_HEAVY    = 2'd2;

    typedef struct packed {
        logic [2:0]  cpu_index;
        logic        cpu_up;
        logic [63:0] total_time;
        logic [63:0] idle_time;
        logic        end_of_round;
    } t_in;

    typedef struct packed {
        logic        sample_valid;
        logic [1:0]  tier_pub;
        logic [1:0]  tier_want;
        logic        tier_changed;
        logic [6:0]  all_load;
        logic [6:0]  lit_load;
        logic [6:0]  mid_load;
        logic [6:0]  big_load;
        logic [10:0] next_delay_ms;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_PCT_START,
        ST_PCT_RUN,
        ST_DECIDE,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       accum;
        logic       pct_start;
        logic       pct_step;
        logic [1:0] pct_sel;
        logic       pct_store;
        logic       decide;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic eor;
        logic had_delta;
        logic pct_last;
    } t_status;

endpackage

FILE: rtl/cltd_datapath.sv
module cltd_datapath #(
    parameter int unsigned NUM_CPUS = cltd_pkg::NUM_CPUS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cltd_pkg::t_in    i_item,
    input  cltd_pkg::t_cmd   i_cmd,
    input  logic [2:0]       i_little_last,
    input  logic [2:0]       i_medium_last,
    input  logic [2:0]       i_heavy_up,
    input  logic [2:0]       i_down,
    input  logic [6:0]       i_heavy_pct,
    input  logic [6:0]       i_mod_pct,
    output cltd_pkg::t_status o_status,
    output cltd_pkg::t_out   o_result
);
    localparam int unsigned IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [63:0] r_last_total [NUM_CPUS];
    logic [63:0] r_last_idle  [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_snap_ok;

    cltd_pkg::t_in r_item;
    logic [63:0] r_cb [3];
    logic [63:0] r_ct [3];
    logic [63:0] r_ob, r_ot;
    logic        r_had;
    logic [1:0]  r_tier;
    logic [2:0]  r_prom, r_dem;
    logic [6:0]  r_pct [4];

    logic [63:0] r_dv_r, r_dv_b, r_dv_d;
    logic [6:0]  r_dv_q, r_dv_cnt;
    logic        r_dv_fix;
    logic [6:0]  r_dv_fixv;

    cltd_pkg::t_out r_result;

    logic        cpu_ok;
    logic [IW-1:0] cidx;
    logic [63:0] dt, di, db, lt, li;
    logic        backwards;
    logic [1:0]  clu;
    logic [63:0] sel_b, sel_t;

    assign cpu_ok = ({29'd0, r_item.cpu_index} < 32'(NUM_CPUS));
    assign cidx   = IW'(r_item.cpu_index);
    assign lt     = r_last_total[cidx];
    assign li     = r_last_idle[cidx];
    assign backwards = (r_item.total_time < lt) || (r_item.idle_time < li);
    assign dt     = r_item.total_time - lt;
    assign di     = r_item.idle_time - li;
    assign db     = (di > dt) ? 64'd0 : dt - di;
    assign clu    = (r_item.cpu_index <= i_little_last) ? 2'd0 :
                    ((r_item.cpu_index <= i_medium_last) ? 2'd1 : 2'd2);

    always_comb begin
        unique case (i_cmd.pct_sel)
            2'd0: begin sel_b = r_ob;    sel_t = r_ot;    end
            2'd1: begin sel_b = r_cb[0]; sel_t = r_ct[0]; end
            2'd2: begin sel_b = r_cb[1]; sel_t = r_ct[1]; end
            default: begin sel_b = r_cb[2]; sel_t = r_ct[2]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.accum && cpu_ok && r_item.cpu_up && r_snap_ok[cidx]) begin
            r_last_total[cidx] <= r_item.total_time;
            r_last_idle[cidx]  <= r_item.idle_time;
        end else if (i_cmd.accum && cpu_ok && r_item.cpu_up) begin
            r_last_total[cidx] <= r_item.total_time;
            r_last_idle[cidx]  <= r_item.idle_time;
        end
        if (i_cmd.pct_start) begin
            r_dv_r   <= '0;
            r_dv_b   <= sel_b;
            r_dv_d   <= sel_t - sel_b;
            r_dv_q   <= '0;
            r_dv_cnt <= '0;
            r_dv_fix <= (sel_t == 64'd0) || (sel_b >= sel_t);
            r_dv_fixv <= (sel_t == 64'd0) ? 7'd0 : 7'd100;
        end else if (i_cmd.pct_step) begin
            r_dv_cnt <= r_dv_cnt + 7'd1;
            if (r_dv_r >= r_dv_d) begin
                r_dv_r <= r_dv_r - r_dv_d;
                r_dv_q <= r_dv_q + 7'd1;
            end else begin
                r_dv_r <= r_dv_r + r_dv_b;
            end
        end
        if (i_cmd.pct_store) begin
            r_pct[i_cmd.pct_sel] <= r_dv_fix ? r_dv_fixv : r_dv_q;
        end
    end

    assign o_status = '{eor:       r_item.end_of_round,
                        had_delta: r_had,
                        pct_last:  (r_dv_cnt == 7'(cltd_pkg::PCT_STEPS - 1))};

    logic [1:0] des;
    logic [2:0] req, prom_inc, dem_inc;
    logic       promote, demote;
    logic [1:0] tier_nx, act;

    always_comb begin
        if (r_pct[0] >= i_heavy_pct || r_pct[2] >= cltd_pkg::MED_HEAVY_PCT ||
            (r_pct[3] >= cltd_pkg::PRIME_HEAVY_PCT &&
             r_pct[2] >= cltd_pkg::MED_ACTIVE_PCT)) begin
            des = cltd_pkg::TIER_HEAVY;
        end else if (r_pct[0] >= i_mod_pct || r_pct[1] >= cltd_pkg::LITTLE_MOD_PCT ||
                     r_pct[2] >= cltd_pkg::MED_ACTIVE_PCT ||
                     r_pct[3] >= cltd_pkg::PRIME_MOD_PCT) begin
            des = cltd_pkg::TIER_MODERATE;
        end else begin
            des = cltd_pkg::TIER_LIGHT;
        end
        req      = (des == cltd_pkg::TIER_HEAVY) ? i_heavy_up : 3'd1;
        prom_inc = (r_prom < cltd_pkg::CNT_MAX) ? r_prom + 3'd1 : r_prom;
        dem_inc  = (r_dem < cltd_pkg::CNT_MAX) ? r_dem + 3'd1 : r_dem;
        promote  = (des > r_tier) && (prom_inc >= req);
        demote   = (des < r_tier) && (dem_inc >= i_down);
        tier_nx  = (promote || demote) ? des : r_tier;
        act      = (tier_nx > des) ? tier_nx : des;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_ok <= '0;
            for (int k = 0; k < 3; k++) begin
                r_cb[k] <= '0;
                r_ct[k] <= '0;
            end
            r_ob   <= '0;
            r_ot   <= '0;
            r_had  <= 1'b0;
            r_tier <= cltd_pkg::TIER_LIGHT;
            r_prom <= '0;
            r_dem  <= '0;
        end else begin
            if (i_cmd.accum && cpu_ok) begin
                if (!r_item.cpu_up) begin
                    r_snap_ok[cidx] <= 1'b0;
                end else if (!r_snap_ok[cidx] || backwards) begin
                    r_snap_ok[cidx] <= 1'b1;
                end else if (dt != 64'd0) begin
                    r_cb[clu] <= r_cb[clu] + db;
                    r_ct[clu] <= r_ct[clu] + dt;
                    r_ob      <= r_ob + db;
                    r_ot      <= r_ot + dt;
                    r_had     <= 1'b1;
                end
            end
            if (i_cmd.decide) begin
                r_result.sample_valid <= r_had;
                r_result.tier_want    <= r_had ? des : cltd_pkg::TIER_LIGHT;
                r_result.all_load     <= r_had ? r_pct[0] : 7'd0;
                r_result.lit_load     <= r_had ? r_pct[1] : 7'd0;
                r_result.mid_load     <= r_had ? r_pct[2] : 7'd0;
                r_result.big_load     <= r_had ? r_pct[3] : 7'd0;
                r_result.tier_pub     <= r_had ? tier_nx : r_tier;
                r_result.tier_changed <= r_had && (promote || demote);
                r_result.next_delay_ms <=
                    (!r_had || act == cltd_pkg::TIER_HEAVY) ? cltd_pkg::DELAY_HEAVY :
                    ((act == cltd_pkg::TIER_MODERATE) ? cltd_pkg::DELAY_MODERATE :
                     cltd_pkg::DELAY_LIGHT);
                if (r_had) begin
                    r_tier <= tier_nx;
                    if (des > r_tier) begin
                        r_dem  <= '0;
                        r_prom <= promote ? 3'd0 : prom_inc;
                    end else if (des < r_tier) begin
                        r_prom <= '0;
                        r_dem  <= demote ? 3'd0 : dem_inc;
                    end else begin
                        r_prom <= '0;
                        r_dem  <= '0;
                    end
                end
            end
            if (i_cmd.clear) begin
                for (int k = 0; k < 3; k++) begin
                    r_cb[k] <= '0;
                    r_ct[k] <= '0;
                end
                r_ob  <= '0;
                r_ot  <= '0;
                r_had <= 1'b0;
            end
        end
    end

    assign o_result = r_result;
endmodule

FILE: rtl/cltd_ctrl.sv
module cltd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  cltd_pkg::t_status i_status,
    output cltd_pkg::t_cmd    o_cmd,
    output logic              o_idle
);
    cltd_pkg::t_state r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cltd_pkg::ST_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.pct_sel = r_sel;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_idle      = 1'b0;
        unique case (r_state)
            cltd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_idle     = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = cltd_pkg::ST_ACCUM;
                end
            end
            cltd_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_sel = '0;
                n_state = !i_status.eor ? cltd_pkg::ST_IDLE : cltd_pkg::ST_PCT_START;
            end
            cltd_pkg::ST_PCT_START: begin
                if (!i_status.had_delta) begin
                    n_state = cltd_pkg::ST_DECIDE;
                end else begin
                    o_cmd.pct_start = 1'b1;
                    n_state = cltd_pkg::ST_PCT_RUN;
                end
            end
            cltd_pkg::ST_PCT_RUN: begin
                o_cmd.pct_step = 1'b1;
                if (i_status.pct_last) begin
                    n_state = cltd_pkg::ST_DECIDE;
                end
            end
            cltd_pkg::ST_DECIDE: begin
                o_cmd.pct_store = i_status.had_delta;
                if (i_status.had_delta && r_sel != 2'd3) begin
                    n_sel = r_sel + 2'd1;
                    n_state = cltd_pkg::ST_PCT_START;
                end else begin
                    n_state = cltd_pkg::ST_EVAL;
                end
            end
            cltd_pkg::ST_EVAL: begin
                o_cmd.decide = 1'b1;
                o_cmd.clear  = 1'b1;
                n_state = cltd_pkg::ST_OUT;
            end
            cltd_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = cltd_pkg::ST_IDLE;
                end
            end
            default: n_state = cltd_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/cpu_load_tier_detector_core.sv
// Flow: a reading without end of round is loaded and accumulated, then the
// core returns to idle; an end of round runs the percent unit on each sum
// if any delta was seen, decides, and waits for the output stall to drop.
// Throughput: one transaction at a time; the shared iterative percent
// unit, run on each sum in turn, sets the end-of-round time.
// Reset: synchronous active low; clears snapshot valid flags, sums, tier, counters,
// and restores register defaults.
module cpu_load_tier_detector_core #(
    parameter int unsigned NUM_CPUS = cltd_pkg::NUM_CPUS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cltd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cltd_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [6:0]     i_cfg_data
);
    logic [2:0] r_little, r_medium, r_hup, r_down;
    logic [6:0] r_hpct, r_mpct;
    cltd_pkg::t_cmd    cmd;
    cltd_pkg::t_status st;
    logic idle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little <= 3'd3;
            r_medium <= 3'd6;
            r_hup    <= 3'd2;
            r_down   <= 3'd4;
            r_hpct   <= 7'd55;
            r_mpct   <= 7'd18;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cltd_pkg::REG_LITTLE_LAST: r_little <= i_cfg_data[2:0];
                cltd_pkg::REG_MEDIUM_LAST: r_medium <= i_cfg_data[2:0];
                cltd_pkg::REG_HEAVY_UP:    r_hup    <= i_cfg_data[2:0];
                cltd_pkg::REG_DOWN:        r_down   <= i_cfg_data[2:0];
                cltd_pkg::REG_HEAVY_PCT:   r_hpct   <= i_cfg_data;
                cltd_pkg::REG_MOD_PCT:     r_mpct   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cltd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (st),
        .o_cmd       (cmd),
        .o_idle      (idle)
    );

    cltd_datapath #(.NUM_CPUS(NUM_CPUS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_in_data),
        .i_cmd         (cmd),
        .i_little_last (r_little),
        .i_medium_last (r_medium),
        .i_heavy_up    (r_hup),
        .i_down        (r_down),
        .i_heavy_pct   (r_hpct),
        .i_mod_pct     (r_mpct),
        .o_status      (st),
        .o_result      (o_out_data)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> idle)
        else $error("input open outside idle");
endmodule

FILE: verif/testbench.sv
module testbench;

    localparam int NCPU       = 8;
    localparam int RAND_ITEMS = 950;
    localparam int IDLE_LIMIT = 20000;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    cltd_pkg::t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    cltd_pkg::t_out o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [6:0] i_cfg_data;

    cpu_load_tier_detector_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // predictor state
    logic [2:0]  p_little_last, p_medium_last, p_heavy_up, p_down;
    logic [6:0]  p_heavy_pct, p_mod_pct;
    logic [63:0] p_last_total [NCPU];
    logic [63:0] p_last_idle [NCPU];
    logic        p_snap_ok [NCPU];
    logic [63:0] p_cl_busy [3];
    logic [63:0] p_cl_total [3];
    logic [63:0] p_all_busy, p_all_total;
    logic        p_had_delta;
    logic [1:0]  p_tier;
    logic [2:0]  p_promote, p_demote;

    cltd_pkg::t_out tier_reports [$];
    int   errors;
    int   n_reports;
    int   n_accepted;
    int   idle_cycles;

    bit idle_free;
    bit hold_off;

    function automatic logic [6:0] busy_pct(logic [63:0] busy, logic [63:0] total);
        logic [71:0] prod;
        if (total == 0) return 7'd0;
        if (busy >= total) return 7'd100;
        prod = {8'd0, busy} * 72'd100;
        return 7'(prod / {8'd0, total});
    endfunction

    task automatic clear_sums();
        for (int c = 0; c < 3; c++) begin
            p_cl_busy[c] = 0;
            p_cl_total[c] = 0;
        end
        p_all_busy = 0;
        p_all_total = 0;
        p_had_delta = 0;
    endtask

    task automatic predictor_reset();
        p_little_last = 3; p_medium_last = 6; p_heavy_up = 2; p_down = 4;
        p_heavy_pct = 55; p_mod_pct = 18;
        for (int c = 0; c < NCPU; c++) begin
            p_last_total[c] = 0;
            p_last_idle[c] = 0;
            p_snap_ok[c] = 0;
        end
        clear_sums();
        p_tier = cltd_pkg::TIER_LIGHT;
        p_promote = 0;
        p_demote = 0;
    endtask

    task automatic predictor_cfg(logic [2:0] idx, logic [6:0] val);
        case (idx)
            cltd_pkg::REG_LITTLE_LAST: p_little_last = val[2:0];
            cltd_pkg::REG_MEDIUM_LAST: p_medium_last = val[2:0];
            cltd_pkg::REG_HEAVY_UP:    p_heavy_up = val[2:0];
            cltd_pkg::REG_DOWN:        p_down = val[2:0];
            cltd_pkg::REG_HEAVY_PCT:   p_heavy_pct = val;
            cltd_pkg::REG_MOD_PCT:     p_mod_pct = val;
            default: ;
        endcase
    endtask

    task automatic predict_tier(cltd_pkg::t_in it);
        logic [63:0] dt, di, db;
        int cl;
        logic [6:0] tp, lp, mp, pp;
        logic [1:0] desired, activity;
        logic [2:0] required;
        logic changed;
        cltd_pkg::t_out r;
        changed = 0;
        if (int'(it.cpu_index) < NCPU) begin
            if (!it.cpu_up) begin
                p_snap_ok[it.cpu_index] = 0;
            end else if (!p_snap_ok[it.cpu_index] ||
                         it.total_time < p_last_total[it.cpu_index] ||
                         it.idle_time < p_last_idle[it.cpu_index]) begin
                p_last_total[it.cpu_index] = it.total_time;
                p_last_idle[it.cpu_index] = it.idle_time;
                p_snap_ok[it.cpu_index] = 1;
            end else begin
                dt = it.total_time - p_last_total[it.cpu_index];
                di = it.idle_time - p_last_idle[it.cpu_index];
                p_last_total[it.cpu_index] = it.total_time;
                p_last_idle[it.cpu_index] = it.idle_time;
                if (dt != 0) begin
                    if (di > dt) di = dt;
                    db = dt - di;
                    cl = (it.cpu_index <= p_little_last) ? 0 :
                         (it.cpu_index <= p_medium_last) ? 1 : 2;
                    p_cl_busy[cl] += db;
                    p_cl_total[cl] += dt;
                    p_all_busy += db;
                    p_all_total += dt;
                    p_had_delta = 1;
                end
            end
        end
        if (!it.end_of_round) return;
        r = '0;
        if (!p_had_delta) begin
            r.tier_pub = p_tier;
            r.next_delay_ms = cltd_pkg::DELAY_HEAVY;
            tier_reports.push_back(r);
            clear_sums();
            return;
        end
        tp = busy_pct(p_all_busy, p_all_total);
        lp = busy_pct(p_cl_busy[0], p_cl_total[0]);
        mp = busy_pct(p_cl_busy[1], p_cl_total[1]);
        pp = busy_pct(p_cl_busy[2], p_cl_total[2]);
        if (tp >= p_heavy_pct || mp >= cltd_pkg::MED_HEAVY_PCT ||
            (pp >= cltd_pkg::PRIME_HEAVY_PCT && mp >= cltd_pkg::MED_ACTIVE_PCT))
            desired = cltd_pkg::TIER_HEAVY;
        else if (tp >= p_mod_pct || lp >= cltd_pkg::LITTLE_MOD_PCT ||
                 mp >= cltd_pkg::MED_ACTIVE_PCT || pp >= cltd_pkg::PRIME_MOD_PCT)
            desired = cltd_pkg::TIER_MODERATE;
        else
            desired = cltd_pkg::TIER_LIGHT;
        if (desired > p_tier) begin
            p_demote = 0;
            if (p_promote < cltd_pkg::CNT_MAX) p_promote++;
            required = (desired == cltd_pkg::TIER_HEAVY) ? p_heavy_up : 3'd1;
            if (p_promote >= required) begin
                p_promote = 0;
                p_tier = desired;
                changed = 1;
            end
        end else if (desired < p_tier) begin
            p_promote = 0;
            if (p_demote < cltd_pkg::CNT_MAX) p_demote++;
            if (p_demote >= p_down) begin
                p_demote = 0;
                p_tier = desired;
                changed = 1;
            end
        end else begin
            p_promote = 0;
            p_demote = 0;
        end
        activity = (p_tier > desired) ? p_tier : desired;
        r.sample_valid = 1;
        r.tier_pub = p_tier;
        r.tier_want = desired;
        r.tier_changed = changed;
        r.all_load = tp;
        r.lit_load = lp;
        r.mid_load = mp;
        r.big_load = pp;
        r.next_delay_ms = (activity == cltd_pkg::TIER_HEAVY) ? cltd_pkg::DELAY_HEAVY :
                          (activity == cltd_pkg::TIER_MODERATE) ? cltd_pkg::DELAY_MODERATE :
                          cltd_pkg::DELAY_LIGHT;
        tier_reports.push_back(r);
        clear_sums();
    endtask

    // output side
    always @(posedge i_clk) begin
        cltd_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_reports++;
                if (tier_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, o_out_data);
                    errors++;
                end else begin
                    want = tier_reports.pop_front();
                    if (want !== o_out_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, want, o_out_data);
                        errors++;
                    end
                end
            end
            i_out_stall <= hold_off ? 1'b1 :
                           (idle_free ? 1'b0 : ($urandom_range(99) < 38));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_reading(cltd_pkg::t_in it);
        while ($urandom_range(99) < 38 && !idle_free) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tier(it);
        n_accepted++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        predictor_cfg(idx, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tier_reports.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    typedef struct {
        logic [2:0]  cpu;
        logic        online;
        logic [63:0] tot;
        logic [63:0] idl;
        logic        eor;
        bit          typed;
        cltd_pkg::t_out want;
    } t_row;

    t_row plan [] = '{
        '{3'd0, 1'b1, 64'd100, 64'd50, 1'b0, 1'b0, '0},
        '{3'd0, 1'b1, 64'd300, 64'd50, 1'b1, 1'b0, '0},
        '{3'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 1'b0, 1'b0, '0},
        '{3'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 1'b0, '0},
        '{3'd4, 1'b1, 64'd1000, 64'd1000, 1'b0, 1'b0, '0},
        '{3'd4, 1'b1, 64'd2000, 64'd5000, 1'b1, 1'b0, '0},
        '{3'd4, 1'b1, 64'd2000, 64'd5000, 1'b1, 1'b1,
          '{1'b0, cltd_pkg::TIER_HEAVY, 2'd0, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 11'd500}},
        '{3'd4, 1'b1, 64'd1000, 64'd9000, 1'b0, 1'b0, '0},
        '{3'd4, 1'b0, 64'd9000, 64'd9000, 1'b1, 1'b1,
          '{1'b0, cltd_pkg::TIER_HEAVY, 2'd0, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 11'd500}},
        '{3'd5, 1'b1, 64'd0, 64'd0, 1'b0, 1'b0, '0},
        '{3'd5, 1'b1, 64'd3, 64'd3, 1'b1, 1'b0, '0},
        '{3'd5, 1'b1, 64'd6, 64'd6, 1'b1, 1'b0, '0},
        '{3'd5, 1'b1, 64'd9, 64'd9, 1'b1, 1'b0, '0},
        '{3'd5, 1'b1, 64'd12, 64'd12, 1'b1, 1'b0, '0},
        '{3'd1, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{3'd1, 1'b1, 64'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0},
        '{3'd2, 1'b1, 64'd1000, 64'd0, 1'b0, 1'b0, '0},
        '{3'd2, 1'b1, 64'd4000, 64'd1, 1'b1, 1'b0, '0}
    };

    int cpu_clock [NCPU];

    initial begin
        cltd_pkg::t_in it;
        int len;
        int mode;
        errors = 0; n_reports = 0; n_accepted = 0;
        idle_free = 0; hold_off = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0; i_in_data = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        predictor_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (plan[k]) begin
            it = '{plan[k].cpu, plan[k].online, plan[k].tot, plan[k].idl, plan[k].eor};
            send_reading(it);
            if (plan[k].typed && tier_reports.size() > 0 &&
                tier_reports[$] !== plan[k].want) begin
                $display("%0t: table row %0d expected %p got %p", $time, k,
                         plan[k].want, tier_reports[$]);
                errors++;
            end
        end
        drain();

        // phases through several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(cltd_pkg::REG_LITTLE_LAST, 7'd0);
                    write_reg(cltd_pkg::REG_MEDIUM_LAST, 7'd7);
                    write_reg(cltd_pkg::REG_HEAVY_UP, 7'd1);
                    write_reg(cltd_pkg::REG_DOWN, 7'd1);
                    write_reg(cltd_pkg::REG_HEAVY_PCT, 7'd100);
                    write_reg(cltd_pkg::REG_MOD_PCT, 7'd0);
                end
                1: begin
                    write_reg(cltd_pkg::REG_LITTLE_LAST, 7'd7);
                    write_reg(cltd_pkg::REG_MEDIUM_LAST, 7'd0);
                    write_reg(cltd_pkg::REG_HEAVY_UP, 7'd7);
                    write_reg(cltd_pkg::REG_DOWN, 7'd7);
                    write_reg(cltd_pkg::REG_HEAVY_PCT, 7'd0);
                    write_reg(cltd_pkg::REG_MOD_PCT, 7'd100);
                    write_reg(REG_SPARE_LO, 7'h7F);
                    write_reg(REG_SPARE_HI, 7'h55);
                end
                2: begin
                    write_reg(cltd_pkg::REG_LITTLE_LAST, 7'h7B);
                    write_reg(cltd_pkg::REG_MEDIUM_LAST, 7'h7D);
                    write_reg(cltd_pkg::REG_HEAVY_UP, 7'd2);
                    write_reg(cltd_pkg::REG_DOWN, 7'd3);
                    write_reg(cltd_pkg::REG_HEAVY_PCT, 7'd127);
                    write_reg(cltd_pkg::REG_MOD_PCT, 7'd127);
                end
                default: begin
                    write_reg(cltd_pkg::REG_LITTLE_LAST, 7'($urandom_range(7)));
                    write_reg(cltd_pkg::REG_MEDIUM_LAST, 7'($urandom_range(7)));
                    write_reg(cltd_pkg::REG_HEAVY_UP, 7'($urandom_range(7)));
                    write_reg(cltd_pkg::REG_DOWN, 7'($urandom_range(7)));
                    write_reg(cltd_pkg::REG_HEAVY_PCT, 7'($urandom_range(100)));
                    write_reg(cltd_pkg::REG_MOD_PCT, 7'($urandom_range(60)));
                end
            endcase
            i_cfg_valid <= 1'b0;
            idle_free = (ph == 3);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            while (n_accepted < (ph + 1) * RAND_ITEMS / 5) begin
                len = $urandom_range(1, 9);
                for (int s = 0; s < len; s++) begin
                    mode = $urandom_range(99);
                    it.cpu_index = 3'($urandom);
                    it.cpu_up = (mode >= 5);
                    if (mode < 80) begin
                        cpu_clock[it.cpu_index] += $urandom_range(0, 5000);
                        it.total_time = 64'(cpu_clock[it.cpu_index]);
                        it.idle_time = 64'(cpu_clock[it.cpu_index]) -
                                       64'($urandom_range(0, 4000));
                        if (mode < 20) it.idle_time = 64'(cpu_clock[it.cpu_index]) / 3;
                    end else if (mode < 90) begin
                        it.total_time = rand64();
                        it.idle_time = rand64();
                    end else begin
                        it.total_time = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                        it.idle_time = 64'($urandom_range(0, 3));
                    end
                    it.end_of_round = (s == len - 1);
                    send_reading(it);
                end
            end
            drain();
        end
        idle_free = 0;

        repeat (200) @(posedge i_clk);
        $display("Covered %0d readings and %0d tier reports over 5 register settings.",
                 n_accepted, n_reports);
        if (errors == 0 && tier_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/cltd_pkg.sv
rtl/cltd_datapath.sv
rtl/cltd_ctrl.sv
rtl/cpu_load_tier_detector_core.sv
verif/testbench.sv
